// ===== src/chacha20_entropy_csprng_defines.svh =====
// assertion macros shared by the checker
`ifndef CHACHA20_ENTROPY_CSPRNG_DEFINES_SVH
`define CHACHA20_ENTROPY_CSPRNG_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CCSP_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("csprng check failed");

// next-cycle implication, disabled in reset
`define CCSP_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("csprng check failed");

`endif

// ===== src/ccsp_pkg.sv =====
package ccsp_pkg;

    // opcodes of one request
    localparam logic [2:0] OP_ADD_ENTROPY = 3'd0;
    localparam logic [2:0] OP_IRQ_EVENT   = 3'd1;
    localparam logic [2:0] OP_READ        = 3'd2;
    localparam logic [2:0] OP_SEED_SLOT   = 3'd3;
    localparam logic [2:0] OP_HW_XOR      = 3'd4;
    localparam logic [2:0] OP_FINISH_INIT = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_REKEY_INTERVAL    = 2'd0;
    localparam logic [1:0] CFG_ENTROPY_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_READY_CREDITS     = 2'd2;

    localparam logic [3:0] MAX_READ_BYTES = 4'd8;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mix_start;
        logic apply;
        logic rd_check;
        logic rd_byte;
        logic rk_xor;
        logic blk_start;
        logic rk_end;
        logic rf_end;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       mix_need;
        logic       mix_done;
        logic       blk_done;
        logic       rd_ok;
        logic       rd_more;
        logic       buf_empty;
        logic       rekey_due;
    } t_sts;

endpackage

// ===== src/ccsp_ctrl.sv =====
module ccsp_ctrl import ccsp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_MIX, S_APPLY, S_RD_CHK, S_RD_LOOP,
        S_RK_XOR, S_RK_GO, S_RK_BLK, S_RK_END,
        S_RF_GO, S_RF_BLK, S_RF_END, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (start) n_state = S_DEC;
            S_DEC: begin
                if (i_sts.mix_need)            n_state = S_MIX;
                else if (i_sts.op == OP_READ)  n_state = S_RD_CHK;
                else                           n_state = S_APPLY;
            end
            S_MIX:     if (i_sts.mix_done) n_state = S_APPLY;
            S_APPLY:   n_state = (i_sts.op == OP_FINISH_INIT) ? S_RK_XOR : S_FIN;
            S_RD_CHK:  n_state = i_sts.rd_ok ? S_RD_LOOP : S_FIN;
            S_RD_LOOP: begin
                priority if (!i_sts.rd_more) n_state = S_FIN;
                else if (i_sts.buf_empty)    n_state = i_sts.rekey_due ? S_RK_XOR : S_RF_GO;
                else                         n_state = S_RD_LOOP;
            end
            S_RK_XOR:  n_state = S_RK_GO;
            S_RK_GO:   n_state = S_RK_BLK;
            S_RK_BLK:  if (i_sts.blk_done) n_state = S_RK_END;
            S_RK_END:  n_state = (i_sts.op == OP_READ) ? S_RF_GO : S_FIN;
            S_RF_GO:   n_state = S_RF_BLK;
            S_RF_BLK:  if (i_sts.blk_done) n_state = S_RF_END;
            S_RF_END:  n_state = S_RD_LOOP;
            S_FIN:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // state and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign busy = r_busy;

    // commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && start;
        o_cmd.mix_start = (r_state == S_DEC) && i_sts.mix_need;
        o_cmd.apply     = (r_state == S_APPLY);
        o_cmd.rd_check  = (r_state == S_RD_CHK);
        o_cmd.rd_byte   = (r_state == S_RD_LOOP) && i_sts.rd_more && !i_sts.buf_empty;
        o_cmd.rk_xor    = (r_state == S_RK_XOR);
        o_cmd.blk_start = (r_state == S_RK_GO) || (r_state == S_RF_GO);
        o_cmd.rk_end    = (r_state == S_RK_END);
        o_cmd.rf_end    = (r_state == S_RF_END);
        o_cmd.finish    = (r_state == S_FIN);
    end

endmodule

// ===== src/ccsp_dp.sv =====
module ccsp_dp import ccsp_pkg::*; #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [2:0]  i_opcode,
    input  logic [63:0] i_entropy_value,
    input  logic [3:0]  i_byte_count,
    input  logic [2:0]  i_seed_slot,
    input  logic [63:0] i_cycle_count,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_valid,
    output logic [63:0] o_random_bytes,
    output logic        o_status,
    output logic        o_ready_res
);

    localparam int QR_TOTAL = 8 * DOUBLE_ROUNDS;
    localparam int QW       = $clog2(QR_TOTAL);
    localparam logic [QW-1:0] QR_LAST = QW'(QR_TOTAL - 1);
    localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;
    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646E;
    localparam logic [31:0] SIGMA2 = 32'h79622D32;
    localparam logic [31:0] SIGMA3 = 32'h6B206574;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_quad;

    function automatic t_quad quarter(input t_quad q);
        t_quad r;
        r = q;
        r.a = r.a + r.b; r.d = r.d ^ r.a; r.d = {r.d[15:0], r.d[31:16]};
        r.c = r.c + r.d; r.b = r.b ^ r.c; r.b = {r.b[19:0], r.b[31:20]};
        r.a = r.a + r.b; r.d = r.d ^ r.a; r.d = {r.d[23:0], r.d[31:24]};
        r.c = r.c + r.d; r.b = r.b ^ r.c; r.b = {r.b[24:0], r.b[31:25]};
        return r;
    endfunction

    // configuration
    logic [15:0] r_rekey_interval;
    logic [7:0]  r_entropy_threshold;
    logic [11:0] r_ready_credits;

    // latched request
    logic [2:0]  r_op;
    logic [63:0] r_val;
    logic [3:0]  r_cnt;
    logic [2:0]  r_slot;
    logic [63:0] r_cyc;

    // generator state
    logic [31:0] r_key [8];
    logic [63:0] r_ctr;
    logic [63:0] r_nonce;
    logic [31:0] r_buf [16];
    logic [6:0]  r_pos;
    logic [15:0] r_blocks;
    logic [63:0] r_acc;
    logic [7:0]  r_events;
    logic [11:0] r_credits;
    logic        r_seeded;
    logic [3:0]  r_hw_mask;

    // read result
    logic [63:0] r_bytes;
    logic        r_status;
    logic [3:0]  r_k;
    logic        r_valid;

    // mix unit
    logic        r_mbusy;
    logic [2:0]  r_mstep;
    logic [63:0] r_mx;
    logic [63:0] r_prod;
    logic [63:0] r_lo;
    logic [31:0] r_cr;

    // block unit
    logic [31:0]   r_w [16];
    logic          r_brun;
    logic [QW-1:0] r_qcnt;

    // request decode
    logic [3:0]  n_add;
    logic [3:0]  n_read;
    logic [63:0] add_v;
    logic [63:0] mix_x0;
    logic        credits_ok;

    always_comb begin
        n_add  = (r_cnt > 4'd8) ? 4'd8 : r_cnt;
        n_read = (r_cnt > MAX_READ_BYTES) ? MAX_READ_BYTES : r_cnt;
        for (int b = 0; b < 8; b++) begin
            add_v[8*b +: 8] = (4'(b) < n_add) ? r_val[8*b +: 8] : 8'd0;
        end
        unique case (r_op)
            OP_ADD_ENTROPY: mix_x0 = add_v ^ r_cyc;
            OP_IRQ_EVENT:   mix_x0 = r_cyc;
            default:        mix_x0 = r_val;
        endcase
    end

    assign credits_ok = (r_credits >= r_ready_credits);

    // saturating credit add
    function automatic logic [11:0] add_credit(input logic [11:0] t, input logic [3:0] n);
        logic [12:0] s;
        s = {1'b0, t} + {9'd0, n};
        return (s > 13'd4095) ? 12'd4095 : s[11:0];
    endfunction

    // block input words and final sums
    logic [31:0] init_w [16];
    logic [31:0] res_w  [16];

    always_comb begin
        init_w[0]  = SIGMA0;
        init_w[1]  = SIGMA1;
        init_w[2]  = SIGMA2;
        init_w[3]  = SIGMA3;
        for (int i = 0; i < 8; i++) begin
            init_w[4+i] = r_key[i];
        end
        init_w[12] = r_ctr[31:0];
        init_w[13] = r_ctr[63:32];
        init_w[14] = r_nonce[31:0];
        init_w[15] = r_nonce[63:32];
        for (int i = 0; i < 16; i++) begin
            res_w[i] = r_w[i] + init_w[i];
        end
    end

    // quarter-round word selection: columns, then diagonals
    logic [1:0] qj;
    logic [3:0] ia, ib, ic, id;
    t_quad      q_in, q_out;

    always_comb begin
        qj = r_qcnt[1:0];
        ia = {2'b00, qj};
        if (!r_qcnt[2]) begin
            ib = {2'b01, qj};
            ic = {2'b10, qj};
            id = {2'b11, qj};
        end else begin
            ib = {2'b01, qj + 2'd1};
            ic = {2'b10, qj + 2'd2};
            id = {2'b11, qj + 2'd3};
        end
        q_in  = '{a: r_w[ia], b: r_w[ib], c: r_w[ic], d: r_w[id]};
        q_out = quarter(q_in);
    end

    // block unit, one quarter-round a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.blk_start) begin
            r_w    <= init_w;
            r_qcnt <= '0;
        end else if (r_brun) begin
            r_w[ia] <= q_out.a;
            r_w[ib] <= q_out.b;
            r_w[ic] <= q_out.c;
            r_w[id] <= q_out.d;
            r_qcnt  <= r_qcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brun <= 1'b0;
        end else if (i_cmd.blk_start) begin
            r_brun <= 1'b1;
        end else if (r_brun && (r_qcnt == QR_LAST)) begin
            r_brun <= 1'b0;
        end
    end

    // mix unit: two 64-bit multiplies from three 32x32 partial products each
    logic [1:0]  msub;
    logic        mphase;
    logic [63:0] mconst;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_y;

    always_comb begin
        msub   = r_mstep[1:0];
        mphase = r_mstep[2];
        mconst = mphase ? MIX_C2 : MIX_C1;
        mul_a  = (msub == 2'd2) ? r_mx[63:32] : r_mx[31:0];
        mul_b  = (msub == 2'd1) ? mconst[63:32] : mconst[31:0];
        mul_y  = {r_lo[63:32] + r_cr + r_prod[31:0], r_lo[31:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix_start) begin
            r_mx <= mix_x0 ^ (mix_x0 >> 30);
        end else if (r_mbusy) begin
            r_prod <= mul_a * mul_b;
            unique case (msub)
                2'd1:    r_lo <= r_prod;
                2'd2:    r_cr <= r_prod[31:0];
                2'd3:    r_mx <= mphase ? (mul_y ^ (mul_y >> 31)) : (mul_y ^ (mul_y >> 27));
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mstep <= '0;
        end else if (i_cmd.mix_start) begin
            r_mbusy <= 1'b1;
            r_mstep <= '0;
        end else if (r_mbusy) begin
            r_mstep <= r_mstep + 1'b1;
            if (r_mstep == 3'd7) r_mbusy <= 1'b0;
        end
    end

    // latched request fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_val  <= i_entropy_value;
            r_cnt  <= i_byte_count;
            r_slot <= i_seed_slot;
            r_cyc  <= i_cycle_count;
        end
    end

    // keystream buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.rf_end) begin
            r_buf <= res_w;
        end
    end

    logic [31:0] rd_word;
    logic [7:0]  rd_byte;
    assign rd_word = r_buf[r_pos[5:2]];
    assign rd_byte = rd_word[8*r_pos[1:0] +: 8];

    // generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rekey_interval    <= 16'd64;
            r_entropy_threshold <= 8'd8;
            r_ready_credits     <= 12'd64;
            for (int i = 0; i < 8; i++) r_key[i] <= '0;
            r_ctr     <= '0;
            r_nonce   <= '0;
            r_pos     <= 7'd64;
            r_blocks  <= '0;
            r_acc     <= '0;
            r_events  <= '0;
            r_credits <= '0;
            r_seeded  <= 1'b0;
            r_hw_mask <= '0;
            r_status  <= 1'b0;
            r_k       <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;

            // register writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_REKEY_INTERVAL:    r_rekey_interval    <= i_cfg_data;
                    CFG_ENTROPY_THRESHOLD: r_entropy_threshold <= i_cfg_data[7:0];
                    CFG_READY_CREDITS:     r_ready_credits     <= i_cfg_data[11:0];
                    default: ;
                endcase
            end

            if (i_cmd.load) begin
                r_status <= 1'b0;
                r_k      <= '0;
            end

            // per-opcode update
            if (i_cmd.apply) begin
                unique case (r_op)
                    OP_ADD_ENTROPY: begin
                        if (n_add != 4'd0) begin
                            r_acc <= r_acc ^ r_mx;
                            if (r_events != 8'd255) r_events <= r_events + 8'd1;
                        end
                        r_credits <= add_credit(r_credits, n_add);
                    end
                    OP_IRQ_EVENT: begin
                        r_acc <= r_acc ^ r_mx;
                        if (r_events != 8'd255) r_events <= r_events + 8'd1;
                        r_credits <= add_credit(r_credits, 4'd1);
                    end
                    OP_SEED_SLOT: begin
                        if (!r_slot[2]) begin
                            r_key[{r_slot[1:0], 1'b0}] <= r_mx[31:0];
                            r_key[{r_slot[1:0], 1'b1}] <= r_mx[63:32];
                        end else if (r_slot[1:0] == 2'd0) begin
                            r_nonce <= r_mx;
                        end
                    end
                    OP_HW_XOR: begin
                        if (!r_slot[2]) begin
                            r_key[{r_slot[1:0], 1'b0}] <= r_key[{r_slot[1:0], 1'b0}] ^ r_val[31:0];
                            r_key[{r_slot[1:0], 1'b1}] <= r_key[{r_slot[1:0], 1'b1}] ^ r_val[63:32];
                            r_hw_mask[r_slot[1:0]] <= 1'b1;
                        end else if (r_slot[1:0] == 2'd0) begin
                            r_nonce <= r_nonce ^ r_val;
                        end
                    end
                    OP_FINISH_INIT: begin
                        r_ctr    <= '0;
                        r_pos    <= 7'd64;
                        r_blocks <= '0;
                        r_acc    <= '0;
                        r_events <= '0;
                        if (r_hw_mask == 4'hF) r_seeded <= 1'b1;
                    end
                    default: ;
                endcase
            end

            // read admission
            if (i_cmd.rd_check) begin
                r_seeded <= r_seeded | credits_ok;
                if (!(r_seeded | credits_ok)) r_status <= 1'b1;
            end

            // rekey: fold accumulator and cycle sample into the key
            if (i_cmd.rk_xor) begin
                r_key[0] <= r_key[0] ^ r_acc[31:0];
                r_key[1] <= r_key[1] ^ r_acc[63:32];
                r_key[2] <= r_key[2] ^ r_acc[31:0] ^ r_acc[63:32];
                r_key[3] <= r_key[3] ^ r_acc[63:32] ^ r_cyc[31:0];
            end

            if (i_cmd.rk_end) begin
                for (int i = 0; i < 8; i++) r_key[i] <= res_w[i];
                r_ctr    <= r_ctr + 64'd1;
                r_acc    <= '0;
                r_events <= '0;
                r_blocks <= '0;
            end

            if (i_cmd.rf_end) begin
                r_ctr <= r_ctr + 64'd1;
                r_pos <= '0;
                if (r_blocks != 16'hFFFF) r_blocks <= r_blocks + 16'd1;
            end

            if (i_cmd.rd_byte) begin
                r_pos <= r_pos + 7'd1;
                r_k   <= r_k + 4'd1;
            end

            if (i_cmd.finish) begin
                r_seeded <= r_seeded | credits_ok;
            end
        end
    end

    // read bytes, cleared per request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bytes <= '0;
        end else if (i_cmd.rd_byte) begin
            r_bytes[8*r_k[2:0] +: 8] <= rd_byte;
        end
    end

    // status to controller
    always_comb begin
        o_sts.op        = r_op;
        o_sts.mix_need  = ((r_op == OP_ADD_ENTROPY) && (r_cnt != 4'd0)) ||
                          (r_op == OP_IRQ_EVENT) || (r_op == OP_SEED_SLOT);
        o_sts.mix_done  = r_mbusy && (r_mstep == 3'd7);
        o_sts.blk_done  = r_brun && (r_qcnt == QR_LAST);
        o_sts.rd_ok     = r_seeded | credits_ok;
        o_sts.rd_more   = (r_k < n_read);
        o_sts.buf_empty = r_pos[6];
        o_sts.rekey_due = (r_blocks >= r_rekey_interval) ||
                          (r_events >= r_entropy_threshold);
    end

    assign o_valid        = r_valid;
    assign o_random_bytes = r_bytes;
    assign o_status       = r_status;
    assign o_ready_res    = r_seeded;

endmodule

// ===== src/chacha20_entropy_csprng.sv =====
// ChaCha20 keystream generator with entropy-driven rekeying. A request is taken when start
// is high and busy is low; its one result shows on the o_ ports for a single cycle with
// o_valid high, and the receiver cannot stall it. Mixed requests (entropy, interrupt, seed)
// also wait on the shared 32x32 multiplier that builds each splitmix product from three
// partial products. When the 64-byte buffer runs dry, a read waits for a refill from the
// single quarter-round unit, and for a rekey block before it when a rekey is due. Finish init
// always runs one block. Configuration writes are always ready and should be made while busy
// is low.
module chacha20_entropy_csprng import ccsp_pkg::*; #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [63:0] i_entropy_value,
    input  logic [3:0]  i_byte_count,
    input  logic [2:0]  i_seed_slot,
    input  logic [63:0] i_cycle_count,
    output logic        o_valid,
    output logic [63:0] o_random_bytes,
    output logic        o_status,
    output logic        o_ready_res
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    // sequencer
    ccsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // state, mix and block units
    ccsp_dp #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_entropy_value (i_entropy_value),
        .i_byte_count    (i_byte_count),
        .i_seed_slot     (i_seed_slot),
        .i_cycle_count   (i_cycle_count),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_random_bytes  (o_random_bytes),
        .o_status        (o_status),
        .o_ready_res     (o_ready_res)
    );

endmodule

// ===== src/ccsp_checker.sv =====
`include "chacha20_entropy_csprng_defines.svh"

module ccsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [63:0] o_random_bytes,
    input logic        o_status,
    input logic        o_ready_res
);

    // results never come in back-to-back cycles
    `CCSP_ASSERT_NEXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid)
    // an accepted request makes the block busy
    `CCSP_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy)
    // a refused read carries no bytes
    `CCSP_ASSERT_IMP(a_refused_zero, i_clk, i_rst_n, o_valid && o_status, o_random_bytes == 64'd0)
    // a refused read means not seeded
    `CCSP_ASSERT_IMP(a_refused_unseeded, i_clk, i_rst_n, o_valid && o_status, !o_ready_res)

endmodule

bind chacha20_entropy_csprng ccsp_checker u_ccsp_checker (.*);
